// ===== rtl/fsas_pkg.sv =====
// ----------------------------------------------------------------------------
// fsas_pkg
// Shared types and constants of the single-precision add/subtract pipeline.
// ----------------------------------------------------------------------------
package fsas_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned EXP_W    = 8;
  localparam int unsigned MANT_W   = 23;
  localparam int unsigned GUARD_W  = 6;
  localparam int unsigned MAX_GAP  = 25;
  localparam logic [31:0] SIGN_MASK = 32'h8000_0000;

  typedef enum logic {
    ACT_ADD = 1'b0,
    ACT_SUB = 1'b1
  } action_t;

  // Signed mantissa with hidden bit and guard bits: 24+6 bits, plus sign.
  typedef logic signed [31:0] smant_t;

endpackage

// ===== rtl/fsas_if.sv =====
// ----------------------------------------------------------------------------
// fsas_in_if / fsas_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface fsas_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  logic        action;
  modport source (output valid, operand_a, operand_b, action, input ready);
  modport sink   (input valid, operand_a, operand_b, action, output ready);
endinterface

interface fsas_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sum_bits;
  modport source (output valid, sum_bits, input ready);
  modport sink   (input valid, sum_bits, output ready);
endinterface

// ===== rtl/float_single_add_sub.sv =====
// ----------------------------------------------------------------------------
// float_single_add_sub
// Single-precision add/subtract in a four-stage valid/ready pipeline.
// ----------------------------------------------------------------------------
// Path: each request is registered in stages 1 to 4 before its result is offered.
// Throughput: one request per cycle; each stage advances when the next is
// free, so a stall at the output backs up the pipeline without losing data.
// Reset: synchronous active-low rst_n clears all stage valid bits; payload
// registers are not reset.
module float_single_add_sub import fsas_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  fsas_in_if.sink  in_ch,
  fsas_out_if.source out_ch
);

  // Stage enables: a stage loads when it is empty or its content moves on.
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  assign en4 = !v4_r || out_ch.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  // ---------------- Stage 1: operand prep, bypass decisions ----------------
  logic [31:0] a_in, b_in;
  logic        byp_nxt;
  logic [31:0] bres_nxt;
  logic [7:0]  ea, eb;
  logic        a_big;
  logic [7:0]  diff_nxt;
  smant_t      ma_nxt, mb_nxt;

  always_comb begin
    a_in = in_ch.operand_a;
    b_in = (action_t'(in_ch.action) == ACT_SUB) ? (in_ch.operand_b ^ SIGN_MASK)
                                                : in_ch.operand_b;
    ea = a_in[30:23];
    eb = b_in[30:23];
    a_big = ea > eb;
    diff_nxt = a_big ? (ea - eb) : (eb - ea);
    byp_nxt  = 1'b1;
    bres_nxt = 32'd0;
    // The first subtract special case tests the raw b operand.
    if (action_t'(in_ch.action) == ACT_SUB && in_ch.operand_b == 32'd0) begin
      bres_nxt = a_in;
    end else if (a_in == 32'd0) begin
      bres_nxt = b_in;
    end else if (b_in == 32'd0) begin
      bres_nxt = a_in;
    end else if ({1'b0, ea} > {1'b0, eb} + 9'(MAX_GAP)) begin
      bres_nxt = a_in;
    end else if ({1'b0, eb} > {1'b0, ea} + 9'(MAX_GAP)) begin
      bres_nxt = b_in;
    end else begin
      byp_nxt = 1'b0;
    end
    ma_nxt = smant_t'({2'b01, a_in[22:0], 6'd0});
    mb_nxt = smant_t'({2'b01, b_in[22:0], 6'd0});
    ma_nxt = {1'b0, ma_nxt[30:0]};
    mb_nxt = {1'b0, mb_nxt[30:0]};
    if (a_in[31]) ma_nxt = -ma_nxt;
    if (b_in[31]) mb_nxt = -mb_nxt;
  end

  logic        byp1_r, abig1_r;
  logic [31:0] bres1_r;
  logic [7:0]  diff1_r, exp1_r;
  smant_t      ma1_r, mb1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_ch.valid;
    end
    if (en1) begin
      byp1_r  <= byp_nxt;
      bres1_r <= bres_nxt;
      abig1_r <= a_big;
      diff1_r <= diff_nxt;
      exp1_r  <= a_big ? ea : eb;
      ma1_r   <= ma_nxt;
      mb1_r   <= mb_nxt;
    end
  end

  // ---------------- Stage 2: align and sum ----------------
  smant_t      sum_nxt;
  logic [31:0] mag2_nxt;

  always_comb begin
    // For non-bypassed items the gap is at most 25, so a 5-bit shift covers it.
    if (abig1_r) begin
      sum_nxt = ma1_r + (mb1_r >>> diff1_r[4:0]);
    end else begin
      sum_nxt = (ma1_r >>> diff1_r[4:0]) + mb1_r;
    end
    mag2_nxt = sum_nxt[31] ? 32'(-sum_nxt) : 32'(sum_nxt);
  end

  logic        byp2_r, sgn2_r;
  logic [31:0] bres2_r, mag2_r;
  logic [7:0]  exp2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
    if (en2) begin
      // Exact cancellation folds into the bypass path as zero.
      byp2_r  <= byp1_r || (sum_nxt == 32'sd0);
      bres2_r <= byp1_r ? bres1_r : 32'd0;
      sgn2_r  <= sum_nxt[31];
      mag2_r  <= mag2_nxt;
      exp2_r  <= exp1_r;
    end
  end

  // ---------------- Stage 3: normalize ----------------
  // The exponent carries a ninth bit from here on so that underflow below
  // zero and overflow past 255 keep the bit that lands on the sign.
  logic [4:0]  nshift;
  logic [31:0] mag3_nxt;
  logic [8:0]  exp3_nxt;

  fsas_norm u_norm (.mag(mag2_r), .shift(nshift));

  always_comb begin
    mag3_nxt = mag2_r << nshift;
    exp3_nxt = {1'b0, exp2_r} - 9'(nshift);
    if (mag3_nxt[30]) begin
      mag3_nxt = mag3_nxt >> 1;
      exp3_nxt = exp3_nxt + 9'd1;
    end
  end

  logic        byp3_r, sgn3_r;
  logic [31:0] bres3_r, mag3_r;
  logic [8:0]  exp3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
    if (en3) begin
      byp3_r  <= byp2_r;
      bres3_r <= bres2_r;
      sgn3_r  <= sgn2_r;
      mag3_r  <= mag3_nxt;
      exp3_r  <= exp3_nxt;
    end
  end

  // ---------------- Stage 4: round and pack ----------------
  logic [31:0] rmag;
  logic [8:0]  rexp;
  logic [31:0] res_nxt;

  always_comb begin
    rmag = mag3_r + (mag3_r[6] ? 32'h20 : 32'h1F);
    rexp = exp3_r;
    if (rmag[30]) begin
      rmag = rmag >> 1;
      rexp = rexp + 9'd1;
    end
    rmag = rmag >> GUARD_W;
    rmag[23] = 1'b0;
    // Exponent bit 8 lands on the sign bit and ORs into it.
    res_nxt = byp3_r ? bres3_r
                     : ({sgn3_r, 31'd0} | {rexp, 23'd0} | rmag);
  end

  logic [31:0] res4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
    if (en4) begin
      res4_r <= res_nxt;
    end
  end

  assign out_ch.valid    = v4_r;
  assign out_ch.sum_bits = res4_r;

  // ---------------- Assertions ----------------
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !out_ch.ready |=> v4_r && $stable(res4_r))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_ch.ready)
    else $error("empty first stage refused a request");
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && en4 |=> v4_r)
    else $error("stage 3 item lost");
  a_norm: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !byp3_r |-> mag3_r[29] && !mag3_r[30])
    else $error("mantissa not normalized");

endmodule

// ===== rtl/fsas_norm.sv =====
// ----------------------------------------------------------------------------
// fsas_norm
// Leading-one search over the 32-bit magnitude: returns the left shift that
// puts the top set bit into bits 31..29 window (top three bits non-zero).
// ----------------------------------------------------------------------------
module fsas_norm import fsas_pkg::*; (
  input  logic [31:0] mag,
  output logic [4:0]  shift
);

  logic [4:0] lz;

  // Count leading zeros, then back off so a one sits in bit 29..31.
  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) begin
        lz = 5'(31 - i);
      end
    end
    shift = (lz > 5'd2) ? (lz - 5'd2) : 5'd0;
  end

endmodule
